@@ hdl/pafe_pkg.sv @@
// Shared types, constants and helpers for the agent and trail field engine.
package pafe_pkg;

  // Default field bounds
  localparam int DEF_MAX_WIDTH  = 512;
  localparam int DEF_MAX_HEIGHT = 512;

  // Beat layouts
  localparam int IN_TDATA_W  = 88;
  localparam int OUT_TDATA_W = 88;

  // Datapath widths
  localparam int MUL_W  = 20;
  localparam int PROD_W = 2 * MUL_W;
  localparam int ACC_W  = PROD_W + 1;
  localparam int RND_W  = ACC_W - 14;
  localparam int VEC_W  = 19;
  localparam int POS_W  = 22;
  localparam int MOD_W  = 16;
  localparam int GRID_W = 10;

  // Register reset values
  localparam logic [9:0]  RST_GRID_WIDTH  = 10'd512;
  localparam logic [9:0]  RST_GRID_HEIGHT = 10'd512;
  localparam logic [31:0] RST_SENSOR_ROT  = 32'd16384;
  localparam logic [31:0] RST_TURN_ROT    = 32'd16384;
  localparam logic [15:0] RST_SENSOR_DIST = 16'd2304;
  localparam logic [15:0] RST_STEP_LEN    = 16'd256;
  localparam logic [15:0] RST_EVAP_FACTOR = 16'd62259;

  localparam logic signed [VEC_W-1:0] DIR_LIMIT = 19'sd16384;
  localparam logic [16:0] DEPOSIT_AMOUNT = 17'd256;

  typedef enum logic [1:0] {
    OP_SENSE   = 2'd0,
    OP_DEPOSIT = 2'd1,
    OP_EVAP    = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    TURN_KEEP  = 2'd0,
    TURN_LEFT  = 2'd1,
    TURN_RIGHT = 2'd2
  } turn_t;

  typedef enum logic [2:0] {
    REG_GRID_WIDTH  = 3'd0,
    REG_GRID_HEIGHT = 3'd1,
    REG_SENSOR_ROT  = 3'd2,
    REG_TURN_ROT    = 3'd3,
    REG_SENSOR_DIST = 3'd4,
    REG_STEP_LEN    = 3'd5,
    REG_EVAP_FACTOR = 3'd6
  } cfg_reg_t;

  typedef enum logic [1:0] {
    MAC_HOLD,
    MAC_LOAD,
    MAC_ADD,
    MAC_SUB
  } mac_op_t;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ROT_A,
    ST_ROT_B,
    ST_ROT_C,
    ST_ROT_D,
    ST_ROT_E,
    ST_PRB_X,
    ST_PRB_Y,
    ST_PRB_Z,
    ST_MOD_LOAD,
    ST_MOD_RUN,
    ST_MOD_FIX,
    ST_ADR_A,
    ST_ADR_B,
    ST_ADR_C,
    ST_MEM_RD,
    ST_MEM_WT,
    ST_EVAP_MUL,
    ST_MEM_WR,
    ST_DECIDE,
    ST_STEP_X,
    ST_STEP_Y,
    ST_STEP_Z,
    ST_DONE
  } state_t;

  // Round half up of a Q.14 product sum: floor((v + 2^13) / 2^14)
  function automatic logic signed [RND_W-1:0] rnd14(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] t;
    t = v + ACC_W'(8192);
    return t[ACC_W-1:14];
  endfunction

endpackage

@@ hdl/physarum_agent_field_engine.sv @@
// Agent sense/turn/move, deposit and evaporate engine over a toroidal trail field.
// After reset the block first sweeps the trail memory to zero, one cell per cycle, over all
// MAX_WIDTH*MAX_HEIGHT cells; s_tready stays low meanwhile while configuration writes are taken.
// Items are then handled one at a time: a beat is taken only in idle, and the block returns to
// idle only once the previous result can enter the output register, so a result waiting for
// m_tready holds off the next beat. The work is done by the 16-step serial remainder unit that
// wraps every cell coordinate (two per probe, three probes plus the final move) and by the single
// multiply-accumulate unit that does every rotation, offset, address and evaporation product. A
// finished result waits in the output register while the next beat is accepted.
module physarum_agent_field_engine import pafe_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // pos_x[16:0], pos_y[33:17], dir_x[49:34], dir_y[65:50], tie_bit[66], cell_index[84:67]
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  // opcode[1:0]
  input  logic [1:0]             s_tuser,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // new_x[16:0], new_y[33:17], new_dir_x[49:34], new_dir_y[65:50], turn_taken[67:66],
  // cell_value[83:68]
  output logic [OUT_TDATA_W-1:0] m_tdata,
  input  logic                   cfg_we,
  input  logic [2:0]             cfg_index,
  input  logic [31:0]            cfg_data
);

  localparam int CELLS = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(CELLS);

  // Configuration registers
  logic [9:0]  grid_width, grid_height;
  logic [31:0] sensor_rotation, turn_rotation;
  logic [15:0] sensor_distance, step_length, evaporate_factor;

  state_t state, state_next;

  // Captured beat
  op_t                in_op;
  logic [16:0]        in_px, in_py;
  logic signed [15:0] in_dx, in_dy;
  logic               in_tie;

  // Result registers
  logic [16:0]        res_x, res_y;
  logic signed [15:0] res_dx, res_dy;
  turn_t              res_turn;
  logic [15:0]        res_value;

  // Sequencer working registers
  logic signed [VEC_W-1:0] vx [3];
  logic signed [VEC_W-1:0] vy [3];
  logic [15:0]             samp [3];
  logic [1:0]              k;
  logic [1:0]              rot_slot;
  logic                    rot_turn, rot_left;
  logic                    step_phase, mod_axis_y;
  logic signed [POS_W-1:0] tx, ty;
  logic [GRID_W-1:0]       cx, cy;
  logic [AW-1:0]           cell_addr, clr_cnt;

  // Shared multiply-accumulate unit
  mac_op_t                  mac_op;
  logic signed [MUL_W-1:0]  mac_a, mac_b;
  logic signed [PROD_W-1:0] mac_prod;
  logic signed [ACC_W-1:0]  acc;
  logic signed [RND_W-1:0]  rnd_val;

  // Serial remainder unit
  logic [GRID_W-1:0]       mod_n, mod_rem, mod_fixed;
  logic [MOD_W-1:0]        mod_mag;
  logic [3:0]              mod_cnt;
  logic                    mod_neg;
  logic signed [POS_W-1:0] mod_src, mod_biased, mod_shift;
  logic signed [MOD_W-1:0] mod_in;
  logic [GRID_W:0]         mod_trial;

  // Memory port
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_addr;
  logic [15:0]   mem_wdata, mem_rdata;
  logic [15:0]   trail_mem [CELLS];

  logic [GRID_W-1:0]       eff_w, eff_h;
  logic signed [15:0]      rot_cos, rot_sin;
  logic signed [VEC_W-1:0] sat_x, sat_y;
  turn_t                   turn_sel;
  logic [16:0]             dep_sum;
  logic [15:0]             dep_value, wr_value;
  logic [31:0]             idx_ext;
  logic                    idx_ok, out_free;

  // Input field slices
  logic [16:0]        s_px, s_py;
  logic signed [15:0] s_dx, s_dy;
  logic               s_tie;
  logic [17:0]        s_idx;

  assign s_px  = s_tdata[16:0];
  assign s_py  = s_tdata[33:17];
  assign s_dx  = s_tdata[49:34];
  assign s_dy  = s_tdata[65:50];
  assign s_tie = s_tdata[66];
  assign s_idx = s_tdata[84:67];

  assign idx_ext  = 32'(s_idx);
  assign idx_ok   = idx_ext < CELLS;
  assign s_tready = (state == ST_IDLE);
  assign out_free = !m_tvalid || m_tready;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width       <= RST_GRID_WIDTH;
      grid_height      <= RST_GRID_HEIGHT;
      sensor_rotation  <= RST_SENSOR_ROT;
      turn_rotation    <= RST_TURN_ROT;
      sensor_distance  <= RST_SENSOR_DIST;
      step_length      <= RST_STEP_LEN;
      evaporate_factor <= RST_EVAP_FACTOR;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_GRID_WIDTH:  grid_width       <= cfg_data[9:0];
        REG_GRID_HEIGHT: grid_height      <= cfg_data[9:0];
        REG_SENSOR_ROT:  sensor_rotation  <= cfg_data;
        REG_TURN_ROT:    turn_rotation    <= cfg_data;
        REG_SENSOR_DIST: sensor_distance  <= cfg_data[15:0];
        REG_STEP_LEN:    step_length      <= cfg_data[15:0];
        REG_EVAP_FACTOR: evaporate_factor <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Effective grid size: zero acts as one, clamp to the store bounds
  always_comb begin
    if (grid_width == '0) eff_w = GRID_W'(1);
    else if (32'(grid_width) > MAX_WIDTH) eff_w = GRID_W'(MAX_WIDTH);
    else eff_w = grid_width;
    if (grid_height == '0) eff_h = GRID_W'(1);
    else if (32'(grid_height) > MAX_HEIGHT) eff_h = GRID_W'(MAX_HEIGHT);
    else eff_h = grid_height;
  end

  // Angle halves of the selected rotation
  always_comb begin
    rot_cos = rot_turn ? turn_rotation[15:0]  : sensor_rotation[15:0];
    rot_sin = rot_turn ? turn_rotation[31:16] : sensor_rotation[31:16];
  end

  // Heading saturation
  always_comb begin
    if (vx[0] > DIR_LIMIT) sat_x = DIR_LIMIT;
    else if (vx[0] < -DIR_LIMIT) sat_x = -DIR_LIMIT;
    else sat_x = vx[0];
    if (vy[0] > DIR_LIMIT) sat_y = DIR_LIMIT;
    else if (vy[0] < -DIR_LIMIT) sat_y = -DIR_LIMIT;
    else sat_y = vy[0];
  end

  // Steering choice from centre, left, right samples
  always_comb begin
    if (samp[0] > samp[1] && samp[0] > samp[2]) turn_sel = TURN_KEEP;
    else if (samp[1] > samp[2]) turn_sel = TURN_LEFT;
    else if (samp[2] > samp[1]) turn_sel = TURN_RIGHT;
    else turn_sel = in_tie ? TURN_LEFT : TURN_RIGHT;
  end

  // Deposit and write-back values
  always_comb begin
    dep_sum   = {1'b0, mem_rdata} + DEPOSIT_AMOUNT;
    dep_value = dep_sum[16] ? 16'hFFFF : dep_sum[15:0];
    wr_value  = (in_op == OP_DEPOSIT) ? dep_value : acc[31:16];
  end

  // Remainder unit input: cell coordinate rounds, move wrap floors
  always_comb begin
    mod_src    = mod_axis_y ? ty : tx;
    mod_biased = step_phase ? mod_src : mod_src + POS_W'(128);
    mod_shift  = mod_biased >>> 8;
    mod_in     = mod_shift[MOD_W-1:0];
    mod_trial  = {mod_rem, mod_mag[MOD_W-1]};
    mod_fixed  = (mod_neg && mod_rem != '0) ? mod_n - mod_rem : mod_rem;
  end

  // MAC datapath
  assign mac_prod = mac_a * mac_b;
  assign rnd_val  = rnd14(acc);

  always_ff @(posedge clk) begin
    case (mac_op)
      MAC_LOAD: acc <= ACC_W'(mac_prod);
      MAC_ADD:  acc <= acc + ACC_W'(mac_prod);
      MAC_SUB:  acc <= acc - ACC_W'(mac_prod);
      default:  ;
    endcase
  end

  // Trail memory, single port
  always_ff @(posedge clk) begin
    if (mem_we) trail_mem[mem_addr] <= mem_wdata;
    if (mem_re) mem_rdata <= trail_mem[mem_addr];
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      clr_cnt <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) clr_cnt <= clr_cnt + AW'(1);
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR:    if (clr_cnt == AW'(CELLS - 1)) state_next = ST_IDLE;
      ST_IDLE: begin
        if (s_tvalid) begin
          unique case (op_t'(s_tuser))
            OP_SENSE:   state_next = ST_ROT_A;
            OP_DEPOSIT: state_next = ST_MOD_LOAD;
            OP_EVAP:    state_next = idx_ok ? ST_MEM_RD : ST_DONE;
            default:    state_next = ST_DONE;
          endcase
        end
      end
      ST_ROT_A:    state_next = ST_ROT_B;
      ST_ROT_B:    state_next = ST_ROT_C;
      ST_ROT_C:    state_next = ST_ROT_D;
      ST_ROT_D:    state_next = ST_ROT_E;
      ST_ROT_E: begin
        if (rot_slot == 2'd0) state_next = ST_STEP_X;
        else if (rot_slot == 2'd1) state_next = ST_ROT_A;
        else state_next = ST_PRB_X;
      end
      ST_PRB_X:    state_next = ST_PRB_Y;
      ST_PRB_Y:    state_next = ST_PRB_Z;
      ST_PRB_Z:    state_next = ST_MOD_LOAD;
      ST_MOD_LOAD: state_next = ST_MOD_RUN;
      ST_MOD_RUN:  if (mod_cnt == '0) state_next = ST_MOD_FIX;
      ST_MOD_FIX: begin
        if (!mod_axis_y) state_next = ST_MOD_LOAD;
        else if (step_phase) state_next = ST_DONE;
        else state_next = ST_ADR_A;
      end
      ST_ADR_A:    state_next = ST_ADR_B;
      ST_ADR_B:    state_next = ST_ADR_C;
      ST_ADR_C:    state_next = ST_MEM_RD;
      ST_MEM_RD:   state_next = ST_MEM_WT;
      ST_MEM_WT: begin
        if (in_op == OP_SENSE) state_next = (k == 2'd2) ? ST_DECIDE : ST_PRB_X;
        else if (in_op == OP_DEPOSIT) state_next = ST_MEM_WR;
        else state_next = ST_EVAP_MUL;
      end
      ST_EVAP_MUL: state_next = ST_MEM_WR;
      ST_MEM_WR:   state_next = ST_DONE;
      ST_DECIDE:   state_next = (turn_sel != TURN_KEEP) ? ST_ROT_A : ST_STEP_X;
      ST_STEP_X:   state_next = ST_STEP_Y;
      ST_STEP_Y:   state_next = ST_STEP_Z;
      ST_STEP_Z:   state_next = ST_MOD_LOAD;
      ST_DONE:     if (out_free) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  // Per-state unit controls
  always_comb begin
    mac_op    = MAC_HOLD;
    mac_a     = '0;
    mac_b     = '0;
    mem_re    = 1'b0;
    mem_we    = 1'b0;
    mem_addr  = cell_addr;
    mem_wdata = wr_value;
    unique case (state)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_addr  = clr_cnt;
        mem_wdata = '0;
      end
      ST_ROT_A: begin
        mac_op = MAC_LOAD;
        mac_a  = MUL_W'(in_dx);
        mac_b  = MUL_W'(rot_cos);
      end
      ST_ROT_B: begin
        mac_op = rot_left ? MAC_ADD : MAC_SUB;
        mac_a  = MUL_W'(in_dy);
        mac_b  = MUL_W'(rot_sin);
      end
      ST_ROT_C: begin
        mac_op = MAC_LOAD;
        mac_a  = MUL_W'(in_dy);
        mac_b  = MUL_W'(rot_cos);
      end
      ST_ROT_D: begin
        mac_op = rot_left ? MAC_SUB : MAC_ADD;
        mac_a  = MUL_W'(in_dx);
        mac_b  = MUL_W'(rot_sin);
      end
      ST_PRB_X: begin
        mac_op = MAC_LOAD;
        mac_a  = MUL_W'(vx[k]);
        mac_b  = MUL_W'(sensor_distance);
      end
      ST_PRB_Y: begin
        mac_op = MAC_LOAD;
        mac_a  = MUL_W'(vy[k]);
        mac_b  = MUL_W'(sensor_distance);
      end
      ST_ADR_A: begin
        mac_op = MAC_LOAD;
        mac_a  = MUL_W'(cy);
        mac_b  = MUL_W'(eff_w);
      end
      ST_ADR_B: begin
        mac_op = MAC_ADD;
        mac_a  = MUL_W'(cx);
        mac_b  = MUL_W'(1);
      end
      ST_MEM_RD:   mem_re = 1'b1;
      ST_EVAP_MUL: begin
        mac_op = MAC_LOAD;
        mac_a  = MUL_W'(mem_rdata);
        mac_b  = MUL_W'(evaporate_factor);
      end
      ST_MEM_WR:   mem_we = 1'b1;
      ST_STEP_X: begin
        mac_op = MAC_LOAD;
        mac_a  = MUL_W'(sat_x);
        mac_b  = MUL_W'(step_length);
      end
      ST_STEP_Y: begin
        mac_op = MAC_LOAD;
        mac_a  = MUL_W'(sat_y);
        mac_b  = MUL_W'(step_length);
      end
      default: ;
    endcase
  end

  // Working registers, updated as the sequencer walks
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          in_op      <= op_t'(s_tuser);
          in_px      <= s_px;
          in_py      <= s_py;
          in_dx      <= s_dx;
          in_dy      <= s_dy;
          in_tie     <= s_tie;
          res_x      <= s_px;
          res_y      <= s_py;
          res_dx     <= s_dx;
          res_dy     <= s_dy;
          res_turn   <= TURN_KEEP;
          res_value  <= '0;
          vx[0]      <= VEC_W'(s_dx);
          vy[0]      <= VEC_W'(s_dy);
          rot_turn   <= 1'b0;
          rot_left   <= 1'b1;
          rot_slot   <= 2'd1;
          step_phase <= 1'b0;
          mod_axis_y <= 1'b0;
          tx         <= POS_W'(s_px);
          ty         <= POS_W'(s_py);
          cell_addr  <= idx_ext[AW-1:0];
        end
      end
      ST_ROT_C: vx[rot_slot] <= rnd_val[VEC_W-1:0];
      ST_ROT_E: begin
        vy[rot_slot] <= rnd_val[VEC_W-1:0];
        if (rot_slot == 2'd1) begin
          rot_slot <= 2'd2;
          rot_left <= 1'b0;
        end else if (rot_slot == 2'd2) begin
          k <= 2'd0;
        end
      end
      ST_PRB_Y:  tx <= POS_W'(in_px) + rnd_val[POS_W-1:0];
      ST_PRB_Z:  ty <= POS_W'(in_py) + rnd_val[POS_W-1:0];
      ST_MOD_LOAD: begin
        mod_n   <= mod_axis_y ? eff_h : eff_w;
        mod_neg <= mod_in[MOD_W-1];
        mod_mag <= mod_in[MOD_W-1] ? MOD_W'(-mod_in) : MOD_W'(mod_in);
        mod_rem <= '0;
        mod_cnt <= 4'hF;
      end
      ST_MOD_RUN: begin
        // one restoring step per cycle
        if (mod_trial >= {1'b0, mod_n}) mod_rem <= GRID_W'(mod_trial - {1'b0, mod_n});
        else mod_rem <= mod_trial[GRID_W-1:0];
        mod_mag <= {mod_mag[MOD_W-2:0], 1'b0};
        mod_cnt <= mod_cnt - 4'd1;
      end
      ST_MOD_FIX: begin
        if (!mod_axis_y) begin
          cx         <= mod_fixed;
          mod_axis_y <= 1'b1;
        end else begin
          cy         <= mod_fixed;
          mod_axis_y <= 1'b0;
          if (step_phase) begin
            res_x <= {cx[8:0], tx[7:0]};
            res_y <= {mod_fixed[8:0], ty[7:0]};
          end
        end
      end
      ST_ADR_C:  cell_addr <= acc[AW-1:0];
      ST_MEM_WT: begin
        if (in_op == OP_SENSE) begin
          samp[k] <= mem_rdata;
          k       <= k + 2'd1;
        end
      end
      ST_MEM_WR: res_value <= wr_value;
      ST_DECIDE: begin
        res_turn <= turn_sel;
        if (turn_sel != TURN_KEEP) begin
          rot_turn <= 1'b1;
          rot_left <= (turn_sel == TURN_LEFT);
          rot_slot <= 2'd0;
        end
      end
      ST_STEP_X: begin
        res_dx     <= sat_x[15:0];
        res_dy     <= sat_y[15:0];
        step_phase <= 1'b1;
      end
      ST_STEP_Y: tx <= POS_W'(in_px) + rnd_val[POS_W-1:0];
      ST_STEP_Z: ty <= POS_W'(in_py) + rnd_val[POS_W-1:0];
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_DONE && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      m_tdata <= {4'b0, res_value, res_turn, res_dy, res_dx, res_y, res_x};
    end
  end

  // Checks
  a_mod_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MOD_FIX) |-> (mod_fixed < mod_n))
    else $error("wrapped coordinate not below grid size");

  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !mem_we)
    else $error("trail write while idle");

  a_turn_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[67:66] == TURN_KEEP || m_tdata[67:66] == TURN_LEFT ||
                  m_tdata[67:66] == TURN_RIGHT))
    else $error("bad turn code on result");

  a_clear_once: assert property (@(posedge clk) disable iff (rst)
    (state != ST_CLEAR) |=> (state != ST_CLEAR))
    else $error("clearing sweep re-entered");

endmodule

@@ sim/physarum_agent_field_engine_tb.sv @@
// Self-checking testbench for the agent and trail field engine.
module physarum_agent_field_engine_tb;
  import pafe_pkg::*;

  localparam int  FIELD_CELLS = DEF_MAX_WIDTH * DEF_MAX_HEIGHT;
  localparam longint CYCLE_LIMIT = 2000000;

  typedef struct {
    op_t         op;
    logic [16:0] px;
    logic [16:0] py;
    logic [15:0] dx;
    logic [15:0] dy;
    logic        tie;
    logic [17:0] idx;
  } agent_beat_t;

  typedef struct {
    logic [16:0] nx;
    logic [16:0] ny;
    logic [15:0] ndx;
    logic [15:0] ndy;
    turn_t       turn;
    logic [15:0] value;
  } agent_result_t;

  logic                   clk;
  logic                   rst;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata;
  logic [1:0]             s_tuser;
  logic                   m_tvalid;
  logic                   m_tready;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   cfg_we;
  logic [2:0]             cfg_index;
  logic [31:0]            cfg_data;

  // Shadow of the field and the registers
  logic [15:0] trail_shadow [0:FIELD_CELLS-1];
  logic [9:0]  grid_w_sh, grid_h_sh;
  logic [31:0] sens_rot_sh, turn_rot_sh;
  logic [15:0] sens_dist_sh, step_len_sh, evap_sh;

  agent_beat_t   pending_beats[$];
  agent_result_t expected_results[$];

  logic   in_done;
  logic   quiet;
  int     in_gap, out_gap;
  longint cycles;
  int     errors, n_sense, n_deposit, n_evap, n_results;

  physarum_agent_field_engine i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Fixed-point helpers
  function automatic longint round_q14(longint v);
    return (v + 64'sd8192) >>> 14;
  endfunction

  function automatic longint wrap_mod(longint v, longint n);
    longint m;
    m = v % n;
    return (m < 0) ? m + n : m;
  endfunction

  function automatic longint eff_dim(logic [9:0] g);
    if (g == 0) return 1;
    return (g > 512) ? 512 : longint'(g);
  endfunction

  function automatic longint clamp_dir(longint v);
    if (v > 16384) return 16384;
    if (v < -16384) return -16384;
    return v;
  endfunction

  function automatic int unsigned cell_addr(longint px, longint py);
    longint w, cx, cy;
    w  = eff_dim(grid_w_sh);
    cx = wrap_mod((px + 128) >>> 8, w);
    cy = wrap_mod((py + 128) >>> 8, eff_dim(grid_h_sh));
    return int'(cy * w + cx);
  endfunction

  function automatic logic [15:0] sense_at(longint px, longint py, longint dx, longint dy);
    longint d;
    d = longint'(sens_dist_sh);
    return trail_shadow[cell_addr(px + round_q14(dx * d), py + round_q14(dy * d))];
  endfunction

  // Works out the result of one beat and updates the shadow field
  function automatic agent_result_t agent_update(agent_beat_t b);
    agent_result_t r;
    longint px, py, dx, dy, c, s, lx, ly, rx, ry, ndx, ndy, st, v;
    logic [15:0] vc, vl, vr;
    int unsigned a;
    px = longint'(b.px);
    py = longint'(b.py);
    dx = longint'($signed(b.dx));
    dy = longint'($signed(b.dy));
    r.nx = b.px;
    r.ny = b.py;
    r.ndx = b.dx;
    r.ndy = b.dy;
    r.turn = TURN_KEEP;
    r.value = '0;
    case (b.op)
      OP_SENSE: begin
        c  = longint'($signed(sens_rot_sh[15:0]));
        s  = longint'($signed(sens_rot_sh[31:16]));
        lx = round_q14(dx * c + dy * s);
        ly = round_q14(dy * c - dx * s);
        rx = round_q14(dx * c - dy * s);
        ry = round_q14(dx * s + dy * c);
        vc = sense_at(px, py, dx, dy);
        vl = sense_at(px, py, lx, ly);
        vr = sense_at(px, py, rx, ry);
        if (vc > vl && vc > vr) r.turn = TURN_KEEP;
        else if (vl > vr) r.turn = TURN_LEFT;
        else if (vr > vl) r.turn = TURN_RIGHT;
        else r.turn = b.tie ? TURN_LEFT : TURN_RIGHT;
        ndx = dx;
        ndy = dy;
        c = longint'($signed(turn_rot_sh[15:0]));
        s = longint'($signed(turn_rot_sh[31:16]));
        if (r.turn == TURN_LEFT) begin
          ndx = round_q14(dx * c + dy * s);
          ndy = round_q14(dy * c - dx * s);
        end else if (r.turn == TURN_RIGHT) begin
          ndx = round_q14(dx * c - dy * s);
          ndy = round_q14(dx * s + dy * c);
        end
        ndx = clamp_dir(ndx);
        ndy = clamp_dir(ndy);
        st = longint'(step_len_sh);
        r.nx = 17'(wrap_mod(px + round_q14(ndx * st), eff_dim(grid_w_sh) * 256));
        r.ny = 17'(wrap_mod(py + round_q14(ndy * st), eff_dim(grid_h_sh) * 256));
        r.ndx = 16'(ndx);
        r.ndy = 16'(ndy);
      end
      OP_DEPOSIT: begin
        a = cell_addr(px, py);
        v = longint'(trail_shadow[a]) + 256;
        if (v > 65535) v = 65535;
        trail_shadow[a] = 16'(v);
        r.value = 16'(v);
      end
      OP_EVAP: begin
        v = (longint'(trail_shadow[b.idx]) * longint'(evap_sh)) >>> 16;
        trail_shadow[b.idx] = 16'(v);
        r.value = 16'(v);
      end
      default: ;
    endcase
    return r;
  endfunction

  // Input driver: new beats appear on the falling edge
  always @(negedge clk) begin
    agent_beat_t b;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || in_done) begin
      if (in_gap > 0) begin
        in_gap--;
        s_tvalid <= 1'b0;
      end else if (pending_beats.size() > 0) begin
        b = pending_beats.pop_front();
        s_tdata  <= {3'b0, b.idx, b.tie, b.dy, b.dx, b.py, b.px};
        s_tuser  <= b.op;
        s_tvalid <= 1'b1;
        if (!quiet && $urandom_range(0, 5) == 0) in_gap = $urandom_range(1, 7);
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Output back-pressure in bursts
  always @(negedge clk) begin
    if (out_gap > 0) begin
      out_gap--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
      if (!quiet && $urandom_range(0, 4) == 0) out_gap = $urandom_range(1, 7);
    end
  end

  // Monitor: register shadow, prediction and result check on the rising edge
  always @(posedge clk) begin
    agent_beat_t   b;
    agent_result_t e, got;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, expected_results.size());
      $display("physarum_agent_field_engine: mismatch");
      $finish;
    end
    in_done <= s_tvalid && s_tready;
    if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_GRID_WIDTH:  grid_w_sh    = cfg_data[9:0];
        REG_GRID_HEIGHT: grid_h_sh    = cfg_data[9:0];
        REG_SENSOR_ROT:  sens_rot_sh  = cfg_data;
        REG_TURN_ROT:    turn_rot_sh  = cfg_data;
        REG_SENSOR_DIST: sens_dist_sh = cfg_data[15:0];
        REG_STEP_LEN:    step_len_sh  = cfg_data[15:0];
        REG_EVAP_FACTOR: evap_sh      = cfg_data[15:0];
        default: ;
      endcase
    end
    // older result first, so a beat taken on the same edge is not matched against it
    if (!rst && m_tvalid && m_tready) begin
      got.nx    = m_tdata[16:0];
      got.ny    = m_tdata[33:17];
      got.ndx   = m_tdata[49:34];
      got.ndy   = m_tdata[65:50];
      got.turn  = turn_t'(m_tdata[67:66]);
      got.value = m_tdata[83:68];
      n_results++;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result beat, actual %h", $time, m_tdata);
        errors++;
      end else begin
        e = expected_results.pop_front();
        if (got.nx !== e.nx) begin
          $display("%0t: new_x expected %0d actual %0d", $time, e.nx, got.nx);
          errors++;
        end
        if (got.ny !== e.ny) begin
          $display("%0t: new_y expected %0d actual %0d", $time, e.ny, got.ny);
          errors++;
        end
        if (got.ndx !== e.ndx) begin
          $display("%0t: new_dir_x expected %0d actual %0d", $time,
                   $signed(e.ndx), $signed(got.ndx));
          errors++;
        end
        if (got.ndy !== e.ndy) begin
          $display("%0t: new_dir_y expected %0d actual %0d", $time,
                   $signed(e.ndy), $signed(got.ndy));
          errors++;
        end
        if (got.turn !== e.turn) begin
          $display("%0t: turn_taken expected %0d actual %0d", $time, e.turn, got.turn);
          errors++;
        end
        if (got.value !== e.value) begin
          $display("%0t: cell_value expected %0d actual %0d", $time, e.value, got.value);
          errors++;
        end
      end
    end
    if (!rst && s_tvalid && s_tready) begin
      b.op  = op_t'(s_tuser);
      b.px  = s_tdata[16:0];
      b.py  = s_tdata[33:17];
      b.dx  = s_tdata[49:34];
      b.dy  = s_tdata[65:50];
      b.tie = s_tdata[66];
      b.idx = s_tdata[84:67];
      case (b.op)
        OP_SENSE:   n_sense++;
        OP_DEPOSIT: n_deposit++;
        OP_EVAP:    n_evap++;
        default: ;
      endcase
      expected_results.push_back(agent_update(b));
    end
  end

  function automatic void queue_beat(op_t op, int px, int py, int dx, int dy, bit tie,
                                     int idx);
    agent_beat_t b;
    b.op = op;
    b.px = 17'(px);
    b.py = 17'(py);
    b.dx = 16'(dx);
    b.dy = 16'(dy);
    b.tie = tie;
    b.idx = 18'(idx);
    pending_beats.push_back(b);
  endfunction

  // Random beats; mostly on the grid, sometimes anywhere in the field range
  task automatic queue_random(int n, int dep_weight);
    int w, h, pick;
    int px, py, idx;
    op_t op;
    w = int'(eff_dim(grid_w_sh));
    h = int'(eff_dim(grid_h_sh));
    repeat (n) begin
      pick = $urandom_range(0, 15);
      if (pick < dep_weight) op = OP_DEPOSIT;
      else if (pick < 13) op = OP_SENSE;
      else if (pick < 15) op = OP_EVAP;
      else op = OP_NONE;
      if ($urandom_range(0, 9) == 0) begin
        px = $urandom_range(0, 131071);
        py = $urandom_range(0, 131071);
      end else begin
        px = $urandom_range(0, w * 256 + 255);
        py = $urandom_range(0, h * 256 + 255);
      end
      idx = ($urandom_range(0, 3) == 0) ? $urandom_range(0, FIELD_CELLS - 1)
                                        : $urandom_range(0, w * h - 1);
      queue_beat(op, px, py, int'($urandom_range(0, 32768)) - 16384,
                 int'($urandom_range(0, 32768)) - 16384, $urandom_range(0, 1), idx);
    end
  endtask

  task automatic write_regs(logic [9:0] gw, logic [9:0] gh, logic [31:0] srot,
                            logic [31:0] trot, logic [15:0] sd, logic [15:0] sl,
                            logic [15:0] ef);
    @(negedge clk);
    cfg_we <= 1'b1; cfg_index <= REG_GRID_WIDTH; cfg_data <= 32'(gw);
    @(negedge clk);
    cfg_index <= REG_GRID_HEIGHT; cfg_data <= 32'(gh);
    @(negedge clk);
    cfg_index <= REG_SENSOR_ROT; cfg_data <= srot;
    @(negedge clk);
    cfg_index <= REG_TURN_ROT; cfg_data <= trot;
    @(negedge clk);
    cfg_index <= REG_SENSOR_DIST; cfg_data <= 32'(sd);
    @(negedge clk);
    cfg_index <= REG_STEP_LEN; cfg_data <= 32'(sl);
    @(negedge clk);
    cfg_index <= REG_EVAP_FACTOR; cfg_data <= 32'(ef);
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Wait for the block to go idle before touching the registers
  task automatic drain;
    while (pending_beats.size() > 0 || expected_results.size() > 0 || s_tvalid)
      @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = OP_NONE;
    m_tready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_GRID_WIDTH;
    cfg_data = '0;
    in_done = 1'b0;
    quiet = 1'b0;
    in_gap = 0;
    out_gap = 0;
    cycles = 0;
    errors = 0;
    n_sense = 0;
    n_deposit = 0;
    n_evap = 0;
    n_results = 0;
    for (int i = 0; i < FIELD_CELLS; i++) trail_shadow[i] = '0;
    grid_w_sh = RST_GRID_WIDTH;
    grid_h_sh = RST_GRID_HEIGHT;
    sens_rot_sh = RST_SENSOR_ROT;
    turn_rot_sh = RST_TURN_ROT;
    sens_dist_sh = RST_SENSOR_DIST;
    step_len_sh = RST_STEP_LEN;
    evap_sh = RST_EVAP_FACTOR;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed beats on the reset settings: axes, edges, ties, rounding, unused opcode
    queue_beat(OP_SENSE, 0, 0, 16384, 0, 1'b0, 0);
    queue_beat(OP_SENSE, 0, 0, -16384, 0, 1'b1, 0);
    queue_beat(OP_SENSE, 131071, 131071, 0, 16384, 1'b0, 0);
    queue_beat(OP_SENSE, 131071, 0, 0, -16384, 1'b1, 0);
    queue_beat(OP_DEPOSIT, 127, 128, 0, 0, 1'b0, 0);
    queue_beat(OP_DEPOSIT, 128, 127, 0, 0, 1'b0, 0);
    queue_beat(OP_DEPOSIT, 9 * 256, 0, 0, 0, 1'b0, 0);
    queue_beat(OP_SENSE, 0, 0, 16384, 0, 1'b0, 0);
    queue_beat(OP_DEPOSIT, 0, 511 * 256, 0, 0, 1'b0, 0);
    queue_beat(OP_DEPOSIT, 0, 511 * 256, 0, 0, 1'b0, 0);
    queue_beat(OP_SENSE, 0, 0, 16384, 0, 1'b1, 0);
    queue_beat(OP_SENSE, 256, 256, -16384, -16384, 1'b0, 262143);
    queue_beat(OP_NONE, 131071, 131071, -16384, 16384, 1'b1, 262143);
    queue_beat(OP_EVAP, 0, 0, 0, 0, 1'b0, 1);
    queue_beat(OP_EVAP, 0, 0, 0, 0, 1'b0, 512 * 511);
    queue_beat(OP_EVAP, 0, 0, 0, 0, 1'b0, 262143);
    queue_beat(OP_DEPOSIT, 131071, 131071, 16384, -16384, 1'b1, 262143);
    queue_beat(OP_SENSE, 511 * 256 + 127, 511 * 256 + 128, 11585, 11585, 1'b1, 0);
    drain();

    // Small grid with random angles: dense trails make real turn decisions
    write_regs(10'd8, 10'd8, $urandom, $urandom, 16'($urandom_range(0, 2047)),
               16'($urandom_range(0, 2047)), 16'($urandom));
    queue_random(160, 6);
    drain();

    // Zero-sized grid acts as one cell: deposits saturate it, full-scale factors
    write_regs(10'd0, 10'd0, 32'hFFFF_FFFF, 32'h0000_0000, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    queue_random(320, 14);
    drain();

    // Oversized grid clamps to the maximum; no reach, no step, clearing evaporation
    write_regs(10'd1023, 10'd600, $urandom, $urandom, 16'h0000, 16'h0000, 16'h0000);
    queue_random(80, 5);
    drain();

    // Odd grid at 45 degrees, no idling on either side
    quiet = 1'b1;
    write_regs(10'd13, 10'd5, {16'd11585, 16'd11585}, {16'hD2BF, 16'd11585}, 16'd768,
               16'd384, 16'd32768);
    queue_random(80, 5);
    drain();

    repeat (200) @(posedge clk);
    $display("%0d results checked: %0d sense, %0d deposit, %0d evaporate beats",
             n_results, n_sense, n_deposit, n_evap);
    $display("grids covered: reset size, 8x8, clamped zero and oversize, 13x5");
    if (errors == 0)
      $display("physarum_agent_field_engine: match");
    else
      $display("physarum_agent_field_engine: mismatch");
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/pafe_pkg.sv
hdl/physarum_agent_field_engine.sv
sim/physarum_agent_field_engine_tb.sv
